[rtl/clpe_pkg.sv]
// Shared types, field widths and operation codes for the circular list engine.
package clpe_pkg;

	localparam int DEFAULT_CAPACITY = 32;
	localparam int VALUE_W          = 32;
	localparam int POS_W            = 6;
	localparam int LEN_W            = 6;
	localparam int FUNC_W           = 3;
	localparam int STATUS_W         = 2;
	localparam int MAX_OUT          = 32;
	localparam int IN_TDATA_W       = 40;
	localparam int OUT_TDATA_W      = 48;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [FUNC_W-1:0]         func_t;
	typedef logic [STATUS_W-1:0]       status_t;

	localparam func_t FUNC_INS_POS = 3'd0;
	localparam func_t FUNC_INS_END = 3'd1;
	localparam func_t FUNC_DEL_POS = 3'd2;
	localparam func_t FUNC_DEL_END = 3'd3;
	localparam func_t FUNC_SEARCH  = 3'd4;
	localparam func_t FUNC_DUMP    = 3'd5;

	localparam status_t STATUS_DONE  = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

endpackage

[rtl/clpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module clpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/circular_list_position_engine_core.sv]
// Circular singly linked list engine: slot pool in two RAMs, tail pointer and free mask.
// Insert at end, and positional insert at the front or into an empty list, need no walk;
// other positional ops, end delete and search walk one link per cycle through the read
// port of the link RAM before the result is registered.
// Dump streams one element per cycle while the result side is ready. One item is in work at a time.
// Reset (arst_n low) empties the list at once; the slot RAMs are not cleared.
module circular_list_position_engine_core #(
	parameter int CAPACITY = clpe_pkg::DEFAULT_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [clpe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // value[31:0], position[37:32]
	input  logic [clpe_pkg::FUNC_W-1:0]        s_axis_tuser,  // func[2:0]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [clpe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // status[1:0], found[2],
	                                                          // element[34:3], length[40:35]
	output logic                               m_axis_tlast
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (CW > clpe_pkg::POS_W) ? CW : clpe_pkg::POS_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FIRST  = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_INS_W1 = 3'd3;
	localparam logic [2:0] S_INS_W2 = 3'd4;
	localparam logic [2:0] S_DEL_W  = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]                   state_q;
	clpe_pkg::func_t              func_q;
	clpe_pkg::value_t             value_q;
	logic [clpe_pkg::POS_W-1:0]   pos_q;
	logic [AW-1:0]                tail_q;
	logic [CW-1:0]                count_q;
	logic [CAPACITY-1:0]          free_q;
	logic [AW-1:0]                cur_q;
	logic [AW-1:0]                prev_q;
	logic [AW-1:0]                slot_q;
	logic [SW-1:0]                step_q;
	logic                         totail_q;
	clpe_pkg::status_t            status_q;
	logic                         found_q;

	logic                         out_valid_q;
	clpe_pkg::status_t            out_status_q;
	logic                         out_found_q;
	clpe_pkg::value_t             out_element_q;
	logic                         out_last_q;
	logic [clpe_pkg::LEN_W-1:0]   out_length_q;

	logic                         in_acc;
	clpe_pkg::func_t              in_func;
	clpe_pkg::value_t             in_value;
	logic [clpe_pkg::POS_W-1:0]   in_pos;
	logic                         out_free;
	logic [AW-1:0]                link_rd;
	clpe_pkg::value_t             value_rd;
	logic [AW-1:0]                rd_addr;
	logic                         rd_en;
	logic                         link_we;
	logic [AW-1:0]                link_waddr;
	logic [AW-1:0]                link_wdata;
	logic                         value_we;
	logic [SW:0]                  step_nx;
	logic [SW:0]                  pos_ext;
	logic [SW:0]                  cnt_ext;
	logic [SW:0]                  dump_n;
	logic                         at_tail;
	logic                         match;
	logic                         dump_last;
	logic                         walk_go;
	logic                         first_direct;
	logic [AW-1:0]                alloc;

	function automatic logic [AW-1:0] lowest_free(input logic [CAPACITY-1:0] mask);
		logic [AW-1:0] idx;
		idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = AW'(i);
			end
		end
		return idx;
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_func       = s_axis_tuser;
	assign in_value      = s_axis_tdata[31:0];
	assign in_pos        = s_axis_tdata[37:32];
	assign out_free      = !out_valid_q || m_axis_tready;

	assign step_nx   = {1'b0, step_q} + 1'b1;
	assign pos_ext   = (SW+1)'(pos_q);
	assign cnt_ext   = (SW+1)'(count_q);
	assign dump_n    = (cnt_ext < (SW+1)'(clpe_pkg::MAX_OUT)) ? cnt_ext
	                   : (SW+1)'(clpe_pkg::MAX_OUT);
	assign at_tail   = (cur_q == tail_q);
	assign match     = (value_rd == value_q);
	assign dump_last = (step_nx == dump_n);
	assign alloc     = lowest_free(free_q);

	// Insert at end, and positional insert at the front or into an empty list, need no walk.
	assign first_direct = (func_q == clpe_pkg::FUNC_INS_END)
	                   || (func_q == clpe_pkg::FUNC_INS_POS && (count_q == '0 || pos_q == '0));

	always_comb begin
		case (func_q)
			clpe_pkg::FUNC_INS_POS: walk_go = !at_tail && (step_nx < pos_ext);
			clpe_pkg::FUNC_DEL_POS: walk_go = !at_tail && ({1'b0, step_q} < pos_ext);
			clpe_pkg::FUNC_DEL_END: walk_go = !at_tail;
			clpe_pkg::FUNC_SEARCH:  walk_go = !match && (step_nx != cnt_ext);
			clpe_pkg::FUNC_DUMP:    walk_go = out_free && !dump_last;
			default:                walk_go = 1'b0;
		endcase
	end

	// Read address is the link just read: one walk step per cycle, on dumps only if out_free.
	always_comb begin
		rd_addr = (state_q == S_IDLE) ? tail_q : link_rd;
		unique case (state_q)
			S_IDLE:  rd_en = 1'b1;
			S_FIRST: rd_en = !first_direct;
			S_WALK:  rd_en = walk_go;
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = alloc;
		link_wdata = (count_q == '0) ? alloc : link_rd;
		value_we   = 1'b0;
		unique case (state_q)
			S_INS_W1: begin
				link_we  = 1'b1;
				value_we = 1'b1;
			end
			S_INS_W2: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = slot_q;
			end
			S_DEL_W: begin
				link_we    = 1'b1;
				link_waddr = prev_q;
				link_wdata = link_rd;
			end
			default: begin
				link_we = 1'b0;
			end
		endcase
	end

	clpe_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	clpe_ram #(.WIDTH(clpe_pkg::VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
		.clk   (clk),
		.we    (value_we),
		.waddr (alloc),
		.wdata (value_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (value_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			func_q   <= clpe_pkg::FUNC_INS_POS;
			value_q  <= '0;
			pos_q    <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			free_q   <= '1;
			cur_q    <= '0;
			prev_q   <= '0;
			slot_q   <= '0;
			step_q   <= '0;
			totail_q <= 1'b0;
			status_q <= clpe_pkg::STATUS_DONE;
			found_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						func_q   <= in_func;
						value_q  <= in_value;
						pos_q    <= in_pos;
						step_q   <= '0;
						found_q  <= 1'b0;
						status_q <= clpe_pkg::STATUS_DONE;
						state_q  <= S_FIRST;
						case (in_func) inside
							clpe_pkg::FUNC_INS_POS, clpe_pkg::FUNC_INS_END: begin
								if (count_q == CW'(CAPACITY)) begin
									status_q <= clpe_pkg::STATUS_FULL;
									state_q  <= S_RESP;
								end
							end
							clpe_pkg::FUNC_DEL_POS, clpe_pkg::FUNC_DEL_END,
							clpe_pkg::FUNC_DUMP: begin
								if (count_q == '0) begin
									status_q <= clpe_pkg::STATUS_EMPTY;
									state_q  <= S_RESP;
								end
							end
							clpe_pkg::FUNC_SEARCH: begin
								if (count_q == '0) begin
									state_q <= S_RESP;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_FIRST: begin
					// Read data holds the head: the successor of the tail.
					if (first_direct) begin
						cur_q    <= tail_q;
						totail_q <= (func_q == clpe_pkg::FUNC_INS_END);
						state_q  <= S_INS_W1;
					end else begin
						cur_q   <= link_rd;
						prev_q  <= tail_q;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_go) begin
						prev_q <= cur_q;
						cur_q  <= link_rd;
						step_q <= step_q + 1'b1;
					end else begin
						case (func_q) inside
							clpe_pkg::FUNC_INS_POS: begin
								totail_q <= at_tail;
								state_q  <= S_INS_W1;
							end
							clpe_pkg::FUNC_DEL_POS, clpe_pkg::FUNC_DEL_END: begin
								state_q <= S_DEL_W;
							end
							clpe_pkg::FUNC_SEARCH: begin
								found_q <= match;
								state_q <= S_RESP;
							end
							clpe_pkg::FUNC_DUMP: begin
								if (out_free) begin
									state_q <= S_IDLE;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_INS_W1: begin
					slot_q <= alloc;
					if (count_q == '0) begin
						tail_q        <= alloc;
						count_q       <= count_q + 1'b1;
						free_q[alloc] <= 1'b0;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_INS_W2;
					end
				end
				S_INS_W2: begin
					if (totail_q) begin
						tail_q <= slot_q;
					end
					count_q        <= count_q + 1'b1;
					free_q[slot_q] <= 1'b0;
					state_q        <= S_RESP;
				end
				S_DEL_W: begin
					if (at_tail) begin
						tail_q <= prev_q;
					end
					count_q       <= count_q - 1'b1;
					free_q[cur_q] <= 1'b1;
					state_q       <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESP && out_free)
		          || (state_q == S_WALK && func_q == clpe_pkg::FUNC_DUMP && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_status_q  <= status_q;
			out_found_q   <= found_q;
			out_element_q <= '0;
			out_last_q    <= 1'b1;
			out_length_q  <= clpe_pkg::LEN_W'(count_q);
		end else if (state_q == S_WALK && func_q == clpe_pkg::FUNC_DUMP && out_free) begin
			out_status_q  <= clpe_pkg::STATUS_DONE;
			out_found_q   <= 1'b0;
			out_element_q <= value_rd;
			out_last_q    <= dump_last;
			out_length_q  <= clpe_pkg::LEN_W'(count_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, out_length_q, out_element_q, out_found_q, out_status_q};

	a_pool_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(count_q) + $countones(free_q)) == CAPACITY)
		else $error("free mask and element count disagree");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ({1'b0, step_q} < cnt_ext))
		else $error("walk went past the list length");

	a_alloc_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_W1) |-> (free_q != '0))
		else $error("insert with no free slot");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("second transfer taken while an item is in work");

	a_resp_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) |-> (count_q <= CW'(CAPACITY)))
		else $error("element count above pool size");

endmodule

[dv/circular_list_position_engine_core_tb.sv]
// Self-checking testbench for the circular list engine: list mirror, stream drivers, result checks.
`timescale 1ns / 100ps

module circular_list_position_engine_core_tb;

	localparam int LIST_CAP     = clpe_pkg::DEFAULT_CAPACITY;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam clpe_pkg::func_t FUNC_SPARE6 = 3'd6;
	localparam clpe_pkg::func_t FUNC_SPARE7 = 3'd7;

	typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

	// Mirror of the list contents; predicts every result that an operation yields.
	class list_mirror;
		typedef struct packed {
			clpe_pkg::status_t          status;
			logic                       found;
			clpe_pkg::value_t           element;
			logic                       last;
			logic [clpe_pkg::LEN_W-1:0] length;
		} list_result_t;

		clpe_pkg::value_t items[$];
		list_result_t     pending[$];
		int               mismatch_count = 0;

		task report(string msg);
			mismatch_count++;
			$display("mismatch: %s", msg);
		endtask

		function void note_op(clpe_pkg::func_t func, clpe_pkg::value_t value,
		                      logic [clpe_pkg::POS_W-1:0] pos);
			list_result_t r;
			int idx;
			int n;
			r = '{status: clpe_pkg::STATUS_DONE, found: 1'b0, element: '0, last: 1'b1,
			      length: '0};
			case (func)
				clpe_pkg::FUNC_INS_POS, clpe_pkg::FUNC_INS_END: begin
					if (items.size() >= LIST_CAP) begin
						r.status = clpe_pkg::STATUS_FULL;
					end else if (func == clpe_pkg::FUNC_INS_END) begin
						items.push_back(value);
					end else begin
						// clamp past the end onto the append place
						idx = (int'(pos) > items.size()) ? items.size() : int'(pos);
						items.insert(idx, value);
					end
				end
				clpe_pkg::FUNC_DEL_POS, clpe_pkg::FUNC_DEL_END: begin
					if (items.size() == 0) begin
						r.status = clpe_pkg::STATUS_EMPTY;
					end else if (func == clpe_pkg::FUNC_DEL_END) begin
						void'(items.pop_back());
					end else begin
						idx = (int'(pos) > items.size() - 1) ? items.size() - 1 : int'(pos);
						items.delete(idx);
					end
				end
				clpe_pkg::FUNC_SEARCH: begin
					foreach (items[i])
						if (items[i] == value)
							r.found = 1'b1;
				end
				clpe_pkg::FUNC_DUMP: begin
					if (items.size() == 0) begin
						r.status = clpe_pkg::STATUS_EMPTY;
					end else begin
						n = (items.size() < clpe_pkg::MAX_OUT) ? items.size() : clpe_pkg::MAX_OUT;
						for (int i = 0; i < n; i++) begin
							r.element = items[i];
							r.last    = (i == n - 1);
							r.length  = clpe_pkg::LEN_W'(items.size());
							pending.push_back(r);
						end
						return;
					end
				end
				default: ;
			endcase
			r.length = clpe_pkg::LEN_W'(items.size());
			pending.push_back(r);
		endfunction

		task check_result(logic [clpe_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
			list_result_t got;
			list_result_t want;
			got.status  = tdata[1:0];
			got.found   = tdata[2];
			got.element = tdata[34:3];
			got.length  = tdata[40:35];
			got.last    = tlast;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending: %h last %b", tdata, tlast));
				return;
			end
			want = pending.pop_front();
			if (got.status != want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.found != want.found)
				report($sformatf("found %b, want %b", got.found, want.found));
			if (got.element != want.element)
				report($sformatf("element %0d, want %0d", got.element, want.element));
			if (got.last != want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
			if (got.length != want.length)
				report($sformatf("length %0d, want %0d", got.length, want.length));
		endtask
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [clpe_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic [clpe_pkg::FUNC_W-1:0]      s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [clpe_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tlast;

	list_mirror mirror = new();
	bit         no_idle   = 0;
	bit         long_hold = 0;

	circular_list_position_engine_core #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one operation and hold it until the transfer completes.
	task send_op(clpe_pkg::func_t func, clpe_pkg::value_t value,
	             logic [clpe_pkg::POS_W-1:0] pos);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, pos, value};
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		mirror.note_op(func, value, pos);
	endtask

	function clpe_pkg::value_t pick_value(clpe_pkg::func_t func);
		if (func == clpe_pkg::FUNC_SEARCH && mirror.items.size() > 0
		    && $urandom_range(0, 1) == 0)
			return mirror.items[$urandom_range(0, mirror.items.size() - 1)];
		if ($urandom_range(0, 3) == 0)
			return clpe_pkg::value_t'($urandom);
		return clpe_pkg::value_t'($urandom_range(0, 31)) - 16;
	endfunction

	function logic [clpe_pkg::POS_W-1:0] pick_pos();
		if ($urandom_range(0, 9) < 7)
			return clpe_pkg::POS_W'($urandom_range(0, mirror.items.size() + 1));
		return clpe_pkg::POS_W'($urandom_range(0, 63));
	endfunction

	task run_phase(phase_t kind, int count);
		int              roll;
		clpe_pkg::func_t func;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			case (kind)
				PH_FILL:
					func = (roll < 45) ? clpe_pkg::FUNC_INS_POS :
					       (roll < 85) ? clpe_pkg::FUNC_INS_END :
					       (roll < 90) ? clpe_pkg::FUNC_DEL_POS :
					       (roll < 95) ? clpe_pkg::FUNC_SEARCH : clpe_pkg::FUNC_DUMP;
				PH_DRAIN:
					func = (roll < 40) ? clpe_pkg::FUNC_DEL_POS :
					       (roll < 80) ? clpe_pkg::FUNC_DEL_END :
					       (roll < 85) ? clpe_pkg::FUNC_INS_POS :
					       (roll < 92) ? clpe_pkg::FUNC_SEARCH : clpe_pkg::FUNC_DUMP;
				default:
					func = (roll < 90) ? clpe_pkg::func_t'($urandom_range(0, 5)) :
					       clpe_pkg::func_t'($urandom_range(6, 7));
			endcase
			send_op(func, pick_value(func), pick_pos());
		end
	endtask

	// Result side: random stalls, one long hold-off on request.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (long_hold) begin
				long_hold = 0;
				stall     = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			mirror.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: deletes and dump report empty, search finds nothing
		send_op(clpe_pkg::FUNC_DEL_POS, 32'sd5, 6'd0);
		send_op(clpe_pkg::FUNC_DEL_END, 32'sd5, 6'd63);
		send_op(clpe_pkg::FUNC_DUMP, 32'sd0, 6'd0);
		send_op(clpe_pkg::FUNC_SEARCH, 32'sd0, 6'd0);
		// inserts at front, end, past the end and in the middle
		send_op(clpe_pkg::FUNC_INS_POS, 32'h7FFF_FFFF, 6'd0);
		send_op(clpe_pkg::FUNC_INS_END, 32'h8000_0000, 6'd0);
		send_op(clpe_pkg::FUNC_INS_POS, -32'sd1, 6'd63);
		send_op(clpe_pkg::FUNC_INS_POS, 32'sd0, 6'd1);
		send_op(clpe_pkg::FUNC_INS_POS, 32'sd1, 6'd0);
		send_op(clpe_pkg::FUNC_DUMP, 32'sd0, 6'd0);
		send_op(clpe_pkg::FUNC_SEARCH, 32'h8000_0000, 6'd0);
		send_op(clpe_pkg::FUNC_SEARCH, 32'sd12345, 6'd0);
		send_op(FUNC_SPARE6, clpe_pkg::value_t'($urandom), 6'd63);
		send_op(FUNC_SPARE7, clpe_pkg::value_t'($urandom), 6'd0);
		// deletes at front, past the end, middle and end
		send_op(clpe_pkg::FUNC_DEL_POS, 32'sd0, 6'd0);
		send_op(clpe_pkg::FUNC_DEL_POS, 32'sd0, 6'd63);
		send_op(clpe_pkg::FUNC_DEL_POS, 32'sd0, 6'd1);
		send_op(clpe_pkg::FUNC_DEL_END, 32'sd0, 6'd0);
		send_op(clpe_pkg::FUNC_DUMP, 32'sd0, 6'd0);
		send_op(clpe_pkg::FUNC_INS_POS, 32'sd77, 6'd32);
		send_op(clpe_pkg::FUNC_SEARCH, 32'sd77, 6'd0);
		send_op(clpe_pkg::FUNC_DUMP, 32'sd0, 6'd0);

		run_phase(PH_FILL, 45);
		// stall the result side on a full dump while items keep coming
		long_hold = 1;
		send_op(clpe_pkg::FUNC_DUMP, 32'sd0, 6'd0);
		run_phase(PH_MIXED, 10);
		no_idle = 1;
		run_phase(PH_DRAIN, 45);
		no_idle = 0;
		run_phase(PH_MIXED, 10);
		no_idle = 1;
		run_phase(PH_FILL, 10);
		no_idle = 0;
		run_phase(PH_FILL, 5);
		send_op(clpe_pkg::FUNC_DUMP, 32'sd0, 6'd0);
		s_axis_tvalid <= 1'b0;

		while (mirror.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.pending.size() != 0)
			mirror.report($sformatf("%0d results never arrived", mirror.pending.size()));

		if (mirror.mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
